/* hdl/iorb_pkg.sv */
package iorb_pkg;

    // Default bank placement on the bus.
    localparam int VIDEO_BASE_DEF       = 53248;
    localparam int SOUND_BASE_DEF       = 54272;
    localparam int ADAPTER_ONE_BASE_DEF = 56320;
    localparam int ADAPTER_TWO_BASE_DEF = 56576;
    localparam int VIDEO_REGS_DEF       = 64;
    localparam int ADAPTER_REGS_DEF     = 16;

    // The sound bank has a fixed size.
    localparam int SOUND_REGS = 32;

    // Bus operation codes.
    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_PRESS   = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    localparam logic [7:0] BYTE_ONES = 8'hFF;

    // Where the result byte of a pending item comes from.
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_MEM,
        SRC_SCAN,
        SRC_ONES
    } t_src;

    // One key press or release headed for the matrix.
    typedef struct packed {
        logic       en;
        logic       press;
        logic [2:0] row;
        logic [2:0] col;
    } t_key_evt;

    // One result item.
    typedef struct packed {
        logic [7:0] read_byte;
        logic       beep;
    } t_result;

    // Reset contents of the video bank.
    function automatic logic [7:0] f_video_init(input logic [7:0] off);
        logic [7:0] val;
        case (off)
            8'h11:   val = 8'h1B;
            8'h16:   val = 8'h08;
            8'h18:   val = 8'h14;
            8'h20:   val = 8'h0F;
            8'h21:   val = 8'h06;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

/* hdl/iorb_ifs.sv */
// Input channel: one bus access or key event per transfer.
interface iorb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
    logic [7:0]  key_code;

    modport source (output valid, operation, bus_address, write_byte, key_code, input ready);
    modport sink   (input valid, operation, bus_address, write_byte, key_code, output ready);
endinterface

// Output channel: one result per transfer.
interface iorb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       beep;

    modport source (output valid, read_byte, beep, input ready);
    modport sink   (input valid, read_byte, beep, output ready);
endinterface

// Configuration write channel for the audio enable.
interface iorb_cfg_if;
    logic valid;
    logic ready;
    logic audio_on;

    modport source (output valid, audio_on, input ready);
    modport sink   (input valid, audio_on, output ready);
endinterface

/* hdl/iorb_bank_ram.sv */
module iorb_bank_ram #(
    parameter int  VIDEO_REGS   = iorb_pkg::VIDEO_REGS_DEF,
    parameter int  ADAPTER_REGS = iorb_pkg::ADAPTER_REGS_DEF,
    localparam int DEPTH        = VIDEO_REGS + iorb_pkg::SOUND_REGS + 2 * ADAPTER_REGS,
    localparam int AW           = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data,
    output logic          o_busy
);
    import iorb_pkg::*;

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] r_clr_idx;
    logic [AW-1:0] n_clr_idx;
    logic          r_busy;
    logic          n_busy;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;

    // The reset pass takes over the write port until every entry holds its reset value.
    always_comb begin
        n_clr_idx = r_clr_idx;
        n_busy    = r_busy;
        if (r_busy) begin
            w_we    = 1'b1;
            w_waddr = r_clr_idx;
            if (int'(r_clr_idx) < VIDEO_REGS) begin
                w_wdata = f_video_init(8'(r_clr_idx));
            end else begin
                w_wdata = 8'h00;
            end
            if (r_clr_idx == AW'(DEPTH - 1)) begin
                n_busy = 1'b0;
            end else begin
                n_clr_idx = r_clr_idx + AW'(1);
            end
        end else begin
            w_we    = i_wr_en;
            w_waddr = i_wr_addr;
            w_wdata = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else begin
            r_busy    <= n_busy;
            r_clr_idx <= n_clr_idx;
        end
    end

    // Storage with one write port and a registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

/* hdl/iorb_key_matrix.sv */
module iorb_key_matrix (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iorb_pkg::t_key_evt i_evt,
    input  logic [7:0]        i_sel,
    output logic [7:0]        o_scan
);
    import iorb_pkg::*;

    logic [7:0] r_rows [8];

    // A press clears the key's bit, a release sets it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 8; r++) begin
                r_rows[r] <= BYTE_ONES;
            end
        end else if (i_evt.en) begin
            if (i_evt.press) begin
                r_rows[i_evt.row] <= r_rows[i_evt.row] & ~(8'h01 << i_evt.col);
            end else begin
                r_rows[i_evt.row] <= r_rows[i_evt.row] | (8'h01 << i_evt.col);
            end
        end
    end

    // Every row whose select bit is low takes part in the scan.
    always_comb begin
        o_scan = BYTE_ONES;
        for (int r = 0; r < 8; r++) begin
            if (!i_sel[r]) begin
                o_scan = o_scan & r_rows[r];
            end
        end
    end

endmodule

/* hdl/iorb_out_queue.sv */
module iorb_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  iorb_pkg::t_result i_data,
    input  logic              i_pop,
    output iorb_pkg::t_result o_head,
    output logic              o_valid,
    output logic [1:0]        o_count
);
    import iorb_pkg::*;

    t_result    r_q [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [1:0] w_slot;

    // A pop moves the second entry to the head; a push lands behind what stays.
    always_comb begin
        w_slot = r_cnt - {1'b0, i_pop};
        n_cnt  = w_slot + {1'b0, i_push};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && (w_slot == 2'd0)) begin
            r_q[0] <= i_data;
        end else if (i_pop) begin
            r_q[0] <= r_q[1];
        end
        if (i_push && (w_slot == 2'd1)) begin
            r_q[1] <= i_data;
        end
    end

    assign o_head  = r_q[0];
    assign o_valid = (r_cnt != 2'd0);
    assign o_count = r_cnt;

endmodule

/* hdl/io_register_banks_with_key_matrix.sv */
// Channel  Direction  Payload                                      Transfer
// i_in     sink       operation, bus_address, write_byte, key_code  valid && ready
// o_out    source     read_byte, beep                              valid && ready
// i_cfg    sink       audio_on                                     valid && ready
//
// A result is pushed in the cycle after its input transfer, once the bank memory's registered
// read completes, and can transfer from the queue head. A two-entry result queue holds
// finished results; input stalls while queued results plus the item in flight reach two, so a
// new item may enter while one is in flight, yet input can stall with the output always ready.
// After reset a clearing pass writes the reset contents into the bank memory, one entry a
// cycle, for VIDEO_REGS + 32 + 2 * ADAPTER_REGS entries (128 by default); no item enters then.
// Reset is synchronous and active low; the configuration channel is always ready.
module io_register_banks_with_key_matrix #(
    parameter int VIDEO_BASE       = iorb_pkg::VIDEO_BASE_DEF,
    parameter int SOUND_BASE       = iorb_pkg::SOUND_BASE_DEF,
    parameter int ADAPTER_ONE_BASE = iorb_pkg::ADAPTER_ONE_BASE_DEF,
    parameter int ADAPTER_TWO_BASE = iorb_pkg::ADAPTER_TWO_BASE_DEF,
    parameter int VIDEO_REGS       = iorb_pkg::VIDEO_REGS_DEF,
    parameter int ADAPTER_REGS     = iorb_pkg::ADAPTER_REGS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iorb_in_if.sink    i_in,
    iorb_out_if.source o_out,
    iorb_cfg_if.sink   i_cfg
);
    import iorb_pkg::*;

    localparam int DEPTH     = VIDEO_REGS + SOUND_REGS + 2 * ADAPTER_REGS;
    localparam int AW        = $clog2(DEPTH);
    localparam int START_SND = VIDEO_REGS;
    localparam int START_A1  = VIDEO_REGS + SOUND_REGS;
    localparam int START_A2  = START_A1 + ADAPTER_REGS;

    logic          r_audio_on;
    logic          r_pend;
    t_src          r_src;
    logic          r_beep;

    logic          w_accept;
    logic [16:0]   w_addr;
    logic          w_hit_v, w_hit_s, w_hit_1, w_hit_2;
    logic [16:0]   w_off_v, w_off_s, w_off_1, w_off_2;
    logic [16:0]   w_loc;
    logic [AW-1:0] w_mem_addr;
    logic          w_mapped;
    t_src          w_src;
    logic          w_beep;
    logic          w_wr_en;
    logic [7:0]    w_rd_data;
    logic          w_busy;
    logic [7:0]    w_scan;
    t_key_evt      w_evt;
    t_result       w_res;
    t_result       w_head;
    logic [1:0]    w_count;
    logic [1:0]    w_occ;
    logic          w_out_valid;

    // Space is kept in the result queue for the item in flight.
    assign w_occ       = w_count + {1'b0, r_pend};
    assign i_in.ready  = !w_busy && (w_occ < 2'd2);
    assign w_accept    = i_in.valid && i_in.ready;

    // Audio enable register.
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_audio_on <= 1'b1;
        end else if (i_cfg.valid) begin
            r_audio_on <= i_cfg.audio_on;
        end
    end

    // Bank decode without wrap-around; the first bank in order wins.
    always_comb begin
        w_addr  = {1'b0, i_in.bus_address};
        w_hit_v = (w_addr >= 17'(VIDEO_BASE)) && (w_addr < 17'(VIDEO_BASE + VIDEO_REGS));
        w_hit_s = (w_addr >= 17'(SOUND_BASE)) && (w_addr < 17'(SOUND_BASE + SOUND_REGS));
        w_hit_1 = (w_addr >= 17'(ADAPTER_ONE_BASE))
               && (w_addr < 17'(ADAPTER_ONE_BASE + ADAPTER_REGS));
        w_hit_2 = (w_addr >= 17'(ADAPTER_TWO_BASE))
               && (w_addr < 17'(ADAPTER_TWO_BASE + ADAPTER_REGS));
        w_off_v = w_addr - 17'(VIDEO_BASE);
        w_off_s = w_addr - 17'(SOUND_BASE);
        w_off_1 = w_addr - 17'(ADAPTER_ONE_BASE);
        w_off_2 = w_addr - 17'(ADAPTER_TWO_BASE);

        w_mapped = 1'b1;
        w_src    = SRC_MEM;
        w_beep   = 1'b0;
        if (w_hit_v) begin
            w_loc = w_off_v;
        end else if (w_hit_s) begin
            w_loc  = w_off_s + 17'(START_SND);
            w_beep = (w_off_s == 17'd1) && r_audio_on;
        end else if (w_hit_1) begin
            w_loc = w_off_1 + 17'(START_A1);
            if (w_off_1 == 17'd0) begin
                w_src = SRC_SCAN;
            end
        end else if (w_hit_2) begin
            w_loc = w_off_2 + 17'(START_A2);
        end else begin
            w_loc    = 17'd0;
            w_mapped = 1'b0;
            w_src    = SRC_ONES;
        end
        w_mem_addr = w_loc[AW-1:0];
    end

    // Writes go straight to the memory at the transfer.
    assign w_wr_en = w_accept && (i_in.operation == OP_WRITE) && w_mapped;

    iorb_bank_ram #(
        .VIDEO_REGS   (VIDEO_REGS),
        .ADAPTER_REGS (ADAPTER_REGS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_mem_addr),
        .i_wr_data (i_in.write_byte),
        .i_rd_addr (w_mem_addr),
        .o_rd_data (w_rd_data),
        .o_busy    (w_busy)
    );

    // Key events update the matrix at the transfer.
    always_comb begin
        w_evt.en    = w_accept
                   && ((i_in.operation == OP_PRESS) || (i_in.operation == OP_RELEASE));
        w_evt.press = (i_in.operation == OP_PRESS);
        w_evt.row   = i_in.key_code[6:4];
        w_evt.col   = i_in.key_code[2:0];
    end

    // The row-select byte arrives on the memory read port for a scan read.
    iorb_key_matrix u_keys (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (w_evt),
        .i_sel   (w_rd_data),
        .o_scan  (w_scan)
    );

    // Item in flight while its memory read completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_src  <= (i_in.operation == OP_READ) ? w_src : SRC_ZERO;
            r_beep <= (i_in.operation == OP_WRITE) && w_beep;
        end
    end

    // Form the result from the read data.
    always_comb begin
        w_res.beep = r_beep;
        case (r_src)
            SRC_MEM:  w_res.read_byte = w_rd_data;
            SRC_SCAN: w_res.read_byte = w_scan;
            SRC_ONES: w_res.read_byte = BYTE_ONES;
            default:  w_res.read_byte = 8'h00;
        endcase
    end

    iorb_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_pend),
        .i_data  (w_res),
        .i_pop   (w_out_valid && o_out.ready),
        .o_head  (w_head),
        .o_valid (w_out_valid),
        .o_count (w_count)
    );

    assign o_out.valid     = w_out_valid;
    assign o_out.read_byte = w_head.read_byte;
    assign o_out.beep      = w_head.beep;

endmodule

/* tb/tb_io_register_banks_with_key_matrix.sv */
`timescale 1ns / 100ps

module tb_io_register_banks_with_key_matrix;
    import iorb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // Bus addresses that the directed tests hit.
    localparam logic [15:0] VIDEO_ADDR      = 16'(VIDEO_BASE_DEF);
    localparam logic [15:0] SOUND_ADDR      = 16'(SOUND_BASE_DEF);
    localparam logic [15:0] ROW_SELECT_ADDR = 16'(ADAPTER_ONE_BASE_DEF);
    localparam logic [15:0] ADAPTER_TWO_ADDR = 16'(ADAPTER_TWO_BASE_DEF);

    logic i_clk = 1'b0;
    logic i_rst_n;

    iorb_in_if  in_ch();
    iorb_out_if out_ch();
    iorb_cfg_if cfg_ch();

    io_register_banks_with_key_matrix dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Shadow copy of the register banks, the key matrix and the audio enable.
    logic [7:0] video_regs [VIDEO_REGS_DEF];
    logic [7:0] sound_regs [SOUND_REGS];
    logic [7:0] adapter_one_regs [ADAPTER_REGS_DEF];
    logic [7:0] adapter_two_regs [ADAPTER_REGS_DEF];
    logic [7:0] key_rows [8];
    logic       audio_en_model;

    t_result pending_results [$];
    t_result want_result;
    int      items_sent = 0;
    int      results_checked = 0;
    int      fail_count = 0;
    int      cycle_count = 0;
    int      out_stall = 0;
    bit      idle_on = 1'b1;

    always #2 i_clk = ~i_clk;

    // Computes the result of one bus access or key event and updates the shadow state.
    function automatic t_result predict_bus_result(input logic [1:0] op,
                                                   input logic [15:0] addr,
                                                   input logic [7:0] wbyte,
                                                   input logic [7:0] key);
        t_result    res;
        int         a;
        int         r;
        logic [7:0] scan;
        logic [2:0] row;
        logic [2:0] col;
        res = '0;
        a = int'(addr);
        row = key[6:4];
        col = key[2:0];
        case (op)
            OP_READ: begin
                if (a >= VIDEO_BASE_DEF && a < VIDEO_BASE_DEF + VIDEO_REGS_DEF) begin
                    res.read_byte = video_regs[a - VIDEO_BASE_DEF];
                end else if (a >= SOUND_BASE_DEF && a < SOUND_BASE_DEF + SOUND_REGS) begin
                    res.read_byte = sound_regs[a - SOUND_BASE_DEF];
                end else if (a >= ADAPTER_ONE_BASE_DEF &&
                             a < ADAPTER_ONE_BASE_DEF + ADAPTER_REGS_DEF) begin
                    if (a == ADAPTER_ONE_BASE_DEF) begin
                        // Rows whose select bit is low are ANDed together.
                        scan = BYTE_ONES;
                        for (r = 0; r < 8; r++) begin
                            if (!adapter_one_regs[0][r]) scan &= key_rows[r];
                        end
                        res.read_byte = scan;
                    end else begin
                        res.read_byte = adapter_one_regs[a - ADAPTER_ONE_BASE_DEF];
                    end
                end else if (a >= ADAPTER_TWO_BASE_DEF &&
                             a < ADAPTER_TWO_BASE_DEF + ADAPTER_REGS_DEF) begin
                    res.read_byte = adapter_two_regs[a - ADAPTER_TWO_BASE_DEF];
                end else begin
                    res.read_byte = BYTE_ONES;
                end
            end
            OP_WRITE: begin
                if (a >= VIDEO_BASE_DEF && a < VIDEO_BASE_DEF + VIDEO_REGS_DEF) begin
                    video_regs[a - VIDEO_BASE_DEF] = wbyte;
                end else if (a >= SOUND_BASE_DEF && a < SOUND_BASE_DEF + SOUND_REGS) begin
                    sound_regs[a - SOUND_BASE_DEF] = wbyte;
                    res.beep = (a == SOUND_BASE_DEF + 1) && audio_en_model;
                end else if (a >= ADAPTER_ONE_BASE_DEF &&
                             a < ADAPTER_ONE_BASE_DEF + ADAPTER_REGS_DEF) begin
                    adapter_one_regs[a - ADAPTER_ONE_BASE_DEF] = wbyte;
                end else if (a >= ADAPTER_TWO_BASE_DEF &&
                             a < ADAPTER_TWO_BASE_DEF + ADAPTER_REGS_DEF) begin
                    adapter_two_regs[a - ADAPTER_TWO_BASE_DEF] = wbyte;
                end
            end
            OP_PRESS: begin
                key_rows[row][col] = 1'b0;
            end
            OP_RELEASE: begin
                key_rows[row][col] = 1'b1;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Brings the shadow state to its reset contents.
    task automatic reset_model();
        foreach (video_regs[i]) video_regs[i] = 8'h00;
        foreach (sound_regs[i]) sound_regs[i] = 8'h00;
        foreach (adapter_one_regs[i]) adapter_one_regs[i] = 8'h00;
        foreach (adapter_two_regs[i]) adapter_two_regs[i] = 8'h00;
        foreach (key_rows[i]) key_rows[i] = 8'hFF;
        video_regs[8'h11] = 8'h1B;
        video_regs[8'h16] = 8'h08;
        video_regs[8'h18] = 8'h14;
        video_regs[8'h20] = 8'h0F;
        video_regs[8'h21] = 8'h06;
        audio_en_model = 1'b1;
    endtask

    // Offers one item and waits for its transfer; may idle afterwards.
    task automatic send_item(input logic [1:0] op, input logic [15:0] addr,
                             input logic [7:0] wbyte, input logic [7:0] key);
        int gap;
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.bus_address <= addr;
        in_ch.write_byte  <= wbyte;
        in_ch.key_code    <= key;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(predict_bus_result(op, addr, wbyte, key));
        items_sent++;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic bus_read(input logic [15:0] addr);
        send_item(OP_READ, addr, 8'($urandom), 8'($urandom));
    endtask

    task automatic bus_write(input logic [15:0] addr, input logic [7:0] wbyte);
        send_item(OP_WRITE, addr, wbyte, 8'($urandom));
    endtask

    task automatic key_event(input logic [1:0] op, input logic [7:0] key);
        send_item(op, 16'($urandom), 8'($urandom), key);
    endtask

    // Picks an address that mostly lands in a bank, near the row select, or anywhere.
    function automatic logic [15:0] pick_address();
        logic [15:0] addr;
        case ($urandom_range(0, 5))
            0: addr = 16'(VIDEO_BASE_DEF + $urandom_range(0, VIDEO_REGS_DEF - 1));
            1: addr = 16'(SOUND_BASE_DEF + $urandom_range(0, SOUND_REGS - 1));
            2: addr = 16'(ADAPTER_ONE_BASE_DEF + $urandom_range(0, ADAPTER_REGS_DEF - 1));
            3: addr = 16'(ADAPTER_TWO_BASE_DEF + $urandom_range(0, ADAPTER_REGS_DEF - 1));
            4: addr = 16'(ADAPTER_ONE_BASE_DEF + $urandom_range(0, 2));
            default: addr = 16'($urandom);
        endcase
        return addr;
    endfunction

    // Sends one item of a random kind.
    task automatic send_random_item();
        logic [1:0] op;
        op = 2'($urandom_range(0, 3));
        case (op)
            OP_READ:  bus_read(pick_address());
            OP_WRITE: bus_write(pick_address(), 8'($urandom));
            default:  key_event(op, 8'($urandom));
        endcase
    endtask

    // Stops offering items and waits until every result has come back.
    task automatic wait_drained();
        if (in_ch.valid) in_ch.valid <= 1'b0;
        while (results_checked != items_sent) @(posedge i_clk);
    endtask

    // Writes the audio enable once the block is idle.
    task automatic set_audio(input logic enable);
        wait_drained();
        cfg_ch.audio_on <= enable;
        cfg_ch.valid    <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        audio_en_model = enable;
        cfg_ch.valid <= 1'b0;
    endtask

    // Reset contents of every bank entry.
    task automatic test_reset_contents();
        for (int i = 0; i < VIDEO_REGS_DEF; i++) bus_read(VIDEO_ADDR + 16'(i));
        for (int i = 0; i < SOUND_REGS; i++) bus_read(SOUND_ADDR + 16'(i));
        for (int i = 0; i < ADAPTER_REGS_DEF; i++) bus_read(ROW_SELECT_ADDR + 16'(i));
        for (int i = 0; i < ADAPTER_REGS_DEF; i++) bus_read(ADAPTER_TWO_ADDR + 16'(i));
    endtask

    // Reads give all ones and writes are dropped outside every bank.
    task automatic test_unmapped_access();
        logic [15:0] holes [9];
        holes = '{VIDEO_ADDR - 16'd1, VIDEO_ADDR + 16'(VIDEO_REGS_DEF),
                  SOUND_ADDR - 16'd1, SOUND_ADDR + 16'(SOUND_REGS),
                  ROW_SELECT_ADDR - 16'd1, ROW_SELECT_ADDR + 16'(ADAPTER_REGS_DEF),
                  ADAPTER_TWO_ADDR + 16'(ADAPTER_REGS_DEF), 16'h0000, 16'hFFFF};
        foreach (holes[i]) begin
            bus_write(holes[i], 8'hA5);
            bus_read(holes[i]);
        end
        bus_read(VIDEO_ADDR + 16'(VIDEO_REGS_DEF - 1));
        bus_read(SOUND_ADDR + 16'(SOUND_REGS - 1));
    endtask

    // Writes land in the decoded bank and read back.
    task automatic test_bank_write_read();
        logic [15:0] addr;
        repeat (50) begin
            addr = pick_address();
            bus_write(addr, 8'($urandom));
            bus_read(addr);
        end
    endtask

    // The beep follows the audio enable on writes of sound offset one only.
    task automatic test_beep();
        bus_write(SOUND_ADDR + 16'd1, 8'h40);
        bus_write(SOUND_ADDR, 8'h11);
        bus_write(SOUND_ADDR + 16'd2, 8'h22);
        bus_read(SOUND_ADDR + 16'd1);
        set_audio(1'b0);
        bus_write(SOUND_ADDR + 16'd1, 8'h41);
        bus_read(SOUND_ADDR + 16'd1);
        set_audio(1'b1);
        bus_write(SOUND_ADDR + 16'd1, 8'h42);
        bus_write(SOUND_ADDR + 16'd1, 8'h43);
    endtask

    // Key presses and releases seen through the row select.
    task automatic test_key_matrix();
        bus_write(ROW_SELECT_ADDR, 8'hFF);
        key_event(OP_PRESS, 8'h23);
        bus_read(ROW_SELECT_ADDR);
        bus_write(ROW_SELECT_ADDR, 8'hFB);
        bus_read(ROW_SELECT_ADDR);
        // Bits 7 and 3 of the key code carry no meaning.
        key_event(OP_PRESS, 8'hDD);
        bus_write(ROW_SELECT_ADDR, 8'hDF);
        bus_read(ROW_SELECT_ADDR);
        bus_write(ROW_SELECT_ADDR, 8'h00);
        bus_read(ROW_SELECT_ADDR);
        key_event(OP_RELEASE, 8'hA3);
        bus_read(ROW_SELECT_ADDR);
        repeat (80) begin
            case ($urandom_range(0, 3))
                0:       key_event(OP_PRESS, 8'($urandom));
                1:       key_event(OP_RELEASE, 8'($urandom));
                2:       bus_write(ROW_SELECT_ADDR, 8'($urandom));
                default: bus_read(ROW_SELECT_ADDR);
            endcase
        end
    endtask

    // Mixed traffic with an occasional change of the audio enable.
    task automatic test_random_traffic();
        repeat (160) begin
            if ($urandom_range(0, 39) == 0) set_audio(1'($urandom));
            send_random_item();
        end
    endtask

    // Items follow each other without idle cycles.
    task automatic test_back_to_back();
        repeat (60) send_random_item();
    endtask

    // The output side idles in random bursts.
    always @(posedge i_clk) begin
        if (out_stall > 0) begin
            out_stall = out_stall - 1;
            out_ch.ready <= (out_stall == 0);
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_stall = $urandom_range(1, 7);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Each result transfer is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual read_byte %02h beep %0b",
                         $time, out_ch.read_byte, out_ch.beep);
                fail_count++;
            end else begin
                want_result = pending_results.pop_front();
                if (out_ch.read_byte !== want_result.read_byte ||
                    out_ch.beep !== want_result.beep) begin
                    $display("%0t: mismatch, expected read_byte %02h beep %0b, %s %02h beep %0b",
                             $time, want_result.read_byte, want_result.beep,
                             "actual read_byte", out_ch.read_byte, out_ch.beep);
                    fail_count++;
                end
            end
            results_checked++;
        end
    end

    // The run stops at a generous cycle limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.audio_on <= 1'b1;
        reset_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_contents();
        test_unmapped_access();
        test_bank_write_read();
        test_beep();
        test_key_matrix();
        test_random_traffic();
        idle_on = 1'b0;
        test_back_to_back();
        wait_drained();

        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
